// ===== rtl/prtt_pkg.sv =====
// shared types, codes and sizes for the periodic task release table
package prtt_pkg;

   localparam int MAX_TASKS = 16;
   localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int SLOT_W    = 4;
   localparam int HANDLE_W  = 8;
   localparam int DATA_W    = 32;
   localparam int OP_W      = 2;
   localparam int KIND_W    = 3;
   localparam int FAULT_W   = 2;

   localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   localparam logic [KIND_W-1:0] KIND_NONE_DUE = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DUE      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ADDED    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_REJECTED = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEARED  = 3'd4;

   localparam logic [FAULT_W-1:0] FAULT_NONE        = 2'd0;
   localparam logic [FAULT_W-1:0] FAULT_TABLE_FULL  = 2'd1;
   localparam logic [FAULT_W-1:0] FAULT_ZERO_PERIOD = 2'd2;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [DATA_W-1:0]   countdown;
      logic [DATA_W-1:0]   period;
      logic [DATA_W-1:0]   runs;
   } prtt_entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      prtt_entry_type   entry;
   } prtt_write_type;

endpackage

// ===== rtl/prtt_slot_alu.sv =====
// shared countdown decrement / counter increment unit, used once per slot visit
module prtt_slot_alu (
   input  logic [prtt_pkg::DATA_W-1:0] dec_operand,
   input  logic [prtt_pkg::DATA_W-1:0] inc_operand,
   output logic [prtt_pkg::DATA_W-1:0] dec_result,
   output logic                        dec_zero,
   output logic [prtt_pkg::DATA_W-1:0] inc_result
);

   assign dec_result = dec_operand - prtt_pkg::DATA_W'(1);
   assign dec_zero   = (dec_result == '0);
   assign inc_result = inc_operand + prtt_pkg::DATA_W'(1);

endmodule

// ===== rtl/prtt_table.sv =====
// slot storage: handle, countdown, period and release count per slot
module prtt_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear,
   input  logic [prtt_pkg::IDX_W-1:0]    rd_idx,
   output prtt_pkg::prtt_entry_type      rd_entry,
   input  prtt_pkg::prtt_write_type      wr
);

   logic [prtt_pkg::HANDLE_W-1:0] handle_ff    [prtt_pkg::MAX_TASKS];
   logic [prtt_pkg::DATA_W-1:0]   countdown_ff [prtt_pkg::MAX_TASKS];
   logic [prtt_pkg::DATA_W-1:0]   period_ff    [prtt_pkg::MAX_TASKS];
   logic [prtt_pkg::DATA_W-1:0]   runs_ff      [prtt_pkg::MAX_TASKS];

   // a zero handle marks an empty slot, so only handles need clearing
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         for (int i = 0; i < prtt_pkg::MAX_TASKS; i++) begin
            handle_ff[i] <= '0;
         end
      end else if (wr.en) begin
         handle_ff[wr.idx] <= wr.entry.handle;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         countdown_ff[wr.idx] <= wr.entry.countdown;
         period_ff[wr.idx]    <= wr.entry.period;
         runs_ff[wr.idx]      <= wr.entry.runs;
      end
   end

   always_comb begin
      rd_entry.handle    = handle_ff[rd_idx];
      rd_entry.countdown = countdown_ff[rd_idx];
      rd_entry.period    = period_ff[rd_idx];
      rd_entry.runs      = runs_ff[rd_idx];
   end

endmodule

// ===== rtl/periodic_task_release_table.sv =====
// top level: sequencer, pending result and output register of the task release table
// A tick visits every slot in index order, one slot per cycle while it is not paused,
// through a single decrement/increment unit; a due slot is held in the pending result
// until the next due slot or the end of the walk, so its last flag is known when it leaves,
// and the walk pauses whenever that held result cannot move into a stalled output register.
// An add searches for the lowest free slot the same way, one slot per cycle, and is
// rejected as full when no slot is free; a clear, or an add rejected for a zero handle or
// a zero period, goes from acceptance through the finish state into the output register.
// Any final load also waits while the output register is stalled. req_stall is high from
// acceptance until the final result of the request is loaded into the output register,
// which may still wait for rsp_stall while the next request is taken.
module periodic_task_release_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [prtt_pkg::OP_W-1:0]     req_operation,
   input  logic [prtt_pkg::HANDLE_W-1:0] req_task_handle,
   input  logic [prtt_pkg::DATA_W-1:0]   req_start_delay,
   input  logic [prtt_pkg::DATA_W-1:0]   req_period,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [prtt_pkg::KIND_W-1:0]   rsp_kind,
   output logic [prtt_pkg::SLOT_W-1:0]   rsp_slot,
   output logic [prtt_pkg::HANDLE_W-1:0] rsp_due_handle,
   output logic [prtt_pkg::DATA_W-1:0]   rsp_run_count,
   output logic [prtt_pkg::FAULT_W-1:0]  rsp_fault,
   output logic                          rsp_last
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_WALK   = 2'd1;
   localparam logic [1:0] ST_SEARCH = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [prtt_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [prtt_pkg::HANDLE_W-1:0] hnd_ff, hnd_in;
   logic [prtt_pkg::DATA_W-1:0] dly_ff, dly_in;
   logic [prtt_pkg::DATA_W-1:0] per_ff, per_in;
   logic [prtt_pkg::FAULT_W-1:0] fault_ff, fault_in;

   logic pend_valid_ff, pend_valid_in;
   logic [prtt_pkg::KIND_W-1:0] pend_kind_ff, pend_kind_in;
   logic [prtt_pkg::IDX_W-1:0] pend_slot_ff, pend_slot_in;
   logic [prtt_pkg::HANDLE_W-1:0] pend_handle_ff, pend_handle_in;
   logic [prtt_pkg::DATA_W-1:0] pend_run_ff, pend_run_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [prtt_pkg::KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [prtt_pkg::SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [prtt_pkg::HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic [prtt_pkg::DATA_W-1:0] rsp_run_ff, rsp_run_in;
   logic [prtt_pkg::FAULT_W-1:0] rsp_fault_ff, rsp_fault_in;
   logic rsp_last_ff, rsp_last_in;

   logic out_free;
   logic last_idx;
   logic table_clear;
   prtt_pkg::prtt_entry_type rd_entry;
   prtt_pkg::prtt_write_type wr;
   logic [prtt_pkg::DATA_W-1:0] inc_operand;
   logic [prtt_pkg::DATA_W-1:0] dec_result;
   logic [prtt_pkg::DATA_W-1:0] inc_result;
   logic dec_zero;

   prtt_table u_table (
      .clock    (clock),
      .reset    (reset),
      .clear    (table_clear),
      .rd_idx   (idx_ff),
      .rd_entry (rd_entry),
      .wr       (wr)
   );

   // the search reuses the incrementer for start_delay + 1
   assign inc_operand = (state_ff == ST_SEARCH) ? dly_ff : rd_entry.runs;

   prtt_slot_alu u_alu (
      .dec_operand (rd_entry.countdown),
      .inc_operand (inc_operand),
      .dec_result  (dec_result),
      .dec_zero    (dec_zero),
      .inc_result  (inc_result)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign last_idx = (idx_ff == prtt_pkg::IDX_W'(prtt_pkg::MAX_TASKS - 1));
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      hnd_in         = hnd_ff;
      dly_in         = dly_ff;
      per_in         = per_ff;
      fault_in       = fault_ff;
      pend_valid_in  = pend_valid_ff;
      pend_kind_in   = pend_kind_ff;
      pend_slot_in   = pend_slot_ff;
      pend_handle_in = pend_handle_ff;
      pend_run_in    = pend_run_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_handle_in  = rsp_handle_ff;
      rsp_run_in     = rsp_run_ff;
      rsp_fault_in   = rsp_fault_ff;
      rsp_last_in    = rsp_last_ff;
      table_clear    = 1'b0;
      wr             = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               hnd_in         = req_task_handle;
               dly_in         = req_start_delay;
               per_in         = req_period;
               idx_in         = '0;
               pend_valid_in  = 1'b0;
               pend_slot_in   = '0;
               pend_handle_in = '0;
               pend_run_in    = '0;
               case (req_operation)
                  prtt_pkg::OP_TICK: begin
                     state_in = ST_WALK;
                  end
                  prtt_pkg::OP_ADD: begin
                     if (req_task_handle == '0) begin
                        pend_valid_in = 1'b1;
                        pend_kind_in  = prtt_pkg::KIND_REJECTED;
                        state_in      = ST_FINISH;
                     end else if (req_period == '0) begin
                        fault_in      = prtt_pkg::FAULT_ZERO_PERIOD;
                        pend_valid_in = 1'b1;
                        pend_kind_in  = prtt_pkg::KIND_REJECTED;
                        state_in      = ST_FINISH;
                     end else begin
                        state_in = ST_SEARCH;
                     end
                  end
                  prtt_pkg::OP_CLEAR: begin
                     table_clear   = 1'b1;
                     fault_in      = prtt_pkg::FAULT_NONE;
                     pend_valid_in = 1'b1;
                     pend_kind_in  = prtt_pkg::KIND_CLEARED;
                     state_in      = ST_FINISH;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_WALK: begin
            // a held due result can only be replaced once it moves to the output
            if (!pend_valid_ff || out_free) begin
               if (rd_entry.handle != '0) begin
                  wr.en           = 1'b1;
                  wr.idx          = idx_ff;
                  wr.entry.handle = rd_entry.handle;
                  wr.entry.period = rd_entry.period;
                  if (dec_zero) begin
                     wr.entry.countdown = rd_entry.period;
                     wr.entry.runs      = inc_result;
                     if (pend_valid_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_kind_in   = pend_kind_ff;
                        rsp_slot_in   = prtt_pkg::SLOT_W'(pend_slot_ff);
                        rsp_handle_in = pend_handle_ff;
                        rsp_run_in    = pend_run_ff;
                        rsp_fault_in  = fault_ff;
                        rsp_last_in   = 1'b0;
                     end
                     pend_valid_in  = 1'b1;
                     pend_kind_in   = prtt_pkg::KIND_DUE;
                     pend_slot_in   = idx_ff;
                     pend_handle_in = rd_entry.handle;
                     pend_run_in    = inc_result;
                  end else begin
                     wr.entry.countdown = dec_result;
                     wr.entry.runs      = rd_entry.runs;
                  end
               end
               if (last_idx) begin
                  state_in = ST_FINISH;
               end else begin
                  idx_in = idx_ff + prtt_pkg::IDX_W'(1);
               end
            end
         end

         ST_SEARCH: begin
            if (rd_entry.handle == '0) begin
               wr.en              = 1'b1;
               wr.idx             = idx_ff;
               wr.entry.handle    = hnd_ff;
               wr.entry.countdown = inc_result;
               wr.entry.period    = per_ff;
               wr.entry.runs      = '0;
               pend_valid_in      = 1'b1;
               pend_kind_in       = prtt_pkg::KIND_ADDED;
               pend_slot_in       = idx_ff;
               state_in           = ST_FINISH;
            end else if (last_idx) begin
               fault_in      = prtt_pkg::FAULT_TABLE_FULL;
               pend_valid_in = 1'b1;
               pend_kind_in  = prtt_pkg::KIND_REJECTED;
               state_in      = ST_FINISH;
            end else begin
               idx_in = idx_ff + prtt_pkg::IDX_W'(1);
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_fault_in = fault_ff;
               rsp_last_in  = 1'b1;
               if (pend_valid_ff) begin
                  rsp_kind_in   = pend_kind_ff;
                  rsp_slot_in   = prtt_pkg::SLOT_W'(pend_slot_ff);
                  rsp_handle_in = pend_handle_ff;
                  rsp_run_in    = pend_run_ff;
               end else begin
                  rsp_kind_in   = prtt_pkg::KIND_NONE_DUE;
                  rsp_slot_in   = '0;
                  rsp_handle_in = '0;
                  rsp_run_in    = '0;
               end
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fault_ff      <= prtt_pkg::FAULT_NONE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fault_ff      <= fault_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      hnd_ff         <= hnd_in;
      dly_ff         <= dly_in;
      per_ff         <= per_in;
      pend_kind_ff   <= pend_kind_in;
      pend_slot_ff   <= pend_slot_in;
      pend_handle_ff <= pend_handle_in;
      pend_run_ff    <= pend_run_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_run_ff     <= rsp_run_in;
      rsp_fault_ff   <= rsp_fault_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_due_handle = rsp_handle_ff;
   assign rsp_run_count  = rsp_run_ff;
   assign rsp_fault      = rsp_fault_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ===== tb/periodic_task_release_table_tb.sv =====
// testbench for the periodic task release table, checked against a shadow table
module periodic_task_release_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [prtt_pkg::OP_W-1:0] OP_UNUSED   = 2'd3;
   localparam int                        CYCLE_LIMIT = 1000000;
   localparam int                        DRAIN_WAIT  = 64;
   localparam int                        RANDOM_REQS = 350;

   typedef struct packed {
      logic [prtt_pkg::OP_W-1:0]     op;
      logic [prtt_pkg::HANDLE_W-1:0] handle;
      logic [prtt_pkg::DATA_W-1:0]   delay;
      logic [prtt_pkg::DATA_W-1:0]   period;
   } table_req_type;

   typedef struct packed {
      logic [prtt_pkg::KIND_W-1:0]   kind;
      logic [prtt_pkg::SLOT_W-1:0]   slot;
      logic [prtt_pkg::HANDLE_W-1:0] handle;
      logic [prtt_pkg::DATA_W-1:0]   runs;
      logic [prtt_pkg::FAULT_W-1:0]  fault;
      logic                          last;
   } table_result_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [prtt_pkg::OP_W-1:0]     req_operation;
   logic [prtt_pkg::HANDLE_W-1:0] req_task_handle;
   logic [prtt_pkg::DATA_W-1:0]   req_start_delay;
   logic [prtt_pkg::DATA_W-1:0]   req_period;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [prtt_pkg::KIND_W-1:0]   rsp_kind;
   logic [prtt_pkg::SLOT_W-1:0]   rsp_slot;
   logic [prtt_pkg::HANDLE_W-1:0] rsp_due_handle;
   logic [prtt_pkg::DATA_W-1:0]   rsp_run_count;
   logic [prtt_pkg::FAULT_W-1:0]  rsp_fault;
   logic                          rsp_last;

   table_req_type    pending_reqs[$];
   table_result_type expected_results[$];

   // shadow copy of the task table
   logic [prtt_pkg::HANDLE_W-1:0] shadow_handle    [prtt_pkg::MAX_TASKS];
   logic [prtt_pkg::DATA_W-1:0]   shadow_countdown [prtt_pkg::MAX_TASKS];
   logic [prtt_pkg::DATA_W-1:0]   shadow_period    [prtt_pkg::MAX_TASKS];
   logic [prtt_pkg::DATA_W-1:0]   shadow_runs      [prtt_pkg::MAX_TASKS];
   logic [prtt_pkg::FAULT_W-1:0]  shadow_fault;

   int  cycle_count = 0;
   int  fail_count  = 0;
   int  req_gap     = 0;
   int  stall_left  = 0;
   bit  req_accepted = 1'b0;
   bit  quiet        = 1'b0;

   periodic_task_release_table dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_task_handle (req_task_handle),
      .req_start_delay (req_start_delay),
      .req_period      (req_period),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_slot        (rsp_slot),
      .rsp_due_handle  (rsp_due_handle),
      .rsp_run_count   (rsp_run_count),
      .rsp_fault       (rsp_fault),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 50) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic void clear_shadow();
      for (int i = 0; i < prtt_pkg::MAX_TASKS; i++) begin
         shadow_handle[i]    = '0;
         shadow_countdown[i] = '0;
         shadow_period[i]    = '0;
         shadow_runs[i]      = '0;
      end
      shadow_fault = prtt_pkg::FAULT_NONE;
   endfunction

   function automatic void push_result(logic [prtt_pkg::KIND_W-1:0] kind,
                                       logic [prtt_pkg::SLOT_W-1:0] slot,
                                       logic [prtt_pkg::HANDLE_W-1:0] handle,
                                       logic [prtt_pkg::DATA_W-1:0] runs,
                                       logic last);
      table_result_type res;
      res = '{kind: kind, slot: slot, handle: handle, runs: runs,
              fault: shadow_fault, last: last};
      expected_results.push_back(res);
   endfunction

   function automatic void predict_table_op(logic [prtt_pkg::OP_W-1:0] op,
                                            logic [prtt_pkg::HANDLE_W-1:0] handle,
                                            logic [prtt_pkg::DATA_W-1:0] delay,
                                            logic [prtt_pkg::DATA_W-1:0] period);
      table_result_type held;
      bit               have_held;
      int               free_idx;
      have_held = 1'b0;
      free_idx  = -1;
      case (op)
         prtt_pkg::OP_TICK: begin
            for (int i = 0; i < prtt_pkg::MAX_TASKS; i++) begin
               if (shadow_handle[i] != '0) begin
                  shadow_countdown[i] = shadow_countdown[i] - 1;
                  if (shadow_countdown[i] == '0) begin
                     shadow_runs[i]      = shadow_runs[i] + 1;
                     shadow_countdown[i] = shadow_period[i];
                     // hold each due slot until we know whether another follows
                     if (have_held) begin
                        expected_results.push_back(held);
                     end
                     held = '{kind: prtt_pkg::KIND_DUE, slot: prtt_pkg::SLOT_W'(i),
                              handle: shadow_handle[i], runs: shadow_runs[i],
                              fault: shadow_fault, last: 1'b0};
                     have_held = 1'b1;
                  end
               end
            end
            if (have_held) begin
               held.last = 1'b1;
               expected_results.push_back(held);
            end else begin
               push_result(prtt_pkg::KIND_NONE_DUE, '0, '0, '0, 1'b1);
            end
         end
         prtt_pkg::OP_ADD: begin
            if (handle == '0) begin
               push_result(prtt_pkg::KIND_REJECTED, '0, '0, '0, 1'b1);
            end else begin
               for (int i = 0; i < prtt_pkg::MAX_TASKS; i++) begin
                  if (free_idx < 0 && shadow_handle[i] == '0) begin
                     free_idx = i;
                  end
               end
               if (period == '0) begin
                  shadow_fault = prtt_pkg::FAULT_ZERO_PERIOD;
                  push_result(prtt_pkg::KIND_REJECTED, '0, '0, '0, 1'b1);
               end else if (free_idx < 0) begin
                  shadow_fault = prtt_pkg::FAULT_TABLE_FULL;
                  push_result(prtt_pkg::KIND_REJECTED, '0, '0, '0, 1'b1);
               end else begin
                  shadow_handle[free_idx]    = handle;
                  shadow_countdown[free_idx] = delay + 1;
                  shadow_period[free_idx]    = period;
                  shadow_runs[free_idx]      = '0;
                  push_result(prtt_pkg::KIND_ADDED, prtt_pkg::SLOT_W'(free_idx), '0, '0,
                              1'b1);
               end
            end
         end
         prtt_pkg::OP_CLEAR: begin
            clear_shadow();
            push_result(prtt_pkg::KIND_CLEARED, '0, '0, '0, 1'b1);
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void note_mismatch(string what, table_result_type want,
                                         table_result_type got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%s: expected kind %0d slot %0d handle %0d runs %0d fault %0d last %0d",
                  what, want.kind, want.slot, want.handle, want.runs, want.fault, want.last);
         $display("   got kind %0d slot %0d handle %0d runs %0d fault %0d last %0d",
                  got.kind, got.slot, got.handle, got.runs, got.fault, got.last);
      end
   endfunction

   function automatic void check_result();
      table_result_type got;
      table_result_type want;
      got = '{kind: rsp_kind, slot: rsp_slot, handle: rsp_due_handle, runs: rsp_run_count,
              fault: rsp_fault, last: rsp_last};
      if (expected_results.size() == 0) begin
         note_mismatch("result with no request waiting", '0, got);
      end else begin
         want = expected_results.pop_front();
         if (got !== want) begin
            note_mismatch("result mismatch", want, got);
         end
      end
   endfunction

   function automatic void queue_req(logic [prtt_pkg::OP_W-1:0] op,
                                     logic [prtt_pkg::HANDLE_W-1:0] handle,
                                     logic [prtt_pkg::DATA_W-1:0] delay,
                                     logic [prtt_pkg::DATA_W-1:0] period);
      table_req_type item;
      item = '{op: op, handle: handle, delay: delay, period: period};
      pending_reqs.push_back(item);
   endfunction

   // monitor: results checked before this edge's request is predicted
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 300 == 0) begin
         quiet <= ($urandom_range(0, 3) == 0);
      end
      if (reset) begin
         req_accepted <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_result();
         end
         req_accepted <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            predict_table_op(req_operation, req_task_handle, req_start_delay, req_period);
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      table_req_type item;
      if (!reset && !(req_valid && !req_accepted)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            item = pending_reqs.pop_front();
            req_valid       <= 1'b1;
            req_operation   <= item.op;
            req_task_handle <= item.handle;
            req_start_delay <= item.delay;
            req_period      <= item.period;
            req_gap = pick_idle();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result-side back pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 3) == 0) begin
            stall_left = pick_idle();
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int                            count;
      int                            r;
      logic [prtt_pkg::OP_W-1:0]     op;
      logic [prtt_pkg::HANDLE_W-1:0] h;
      logic [prtt_pkg::DATA_W-1:0]   d;
      logic [prtt_pkg::DATA_W-1:0]   p;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_operation   = prtt_pkg::OP_TICK;
      req_task_handle = '0;
      req_start_delay = '0;
      req_period      = '0;
      rsp_stall       = 1'b0;
      clear_shadow();

      // directed part
      queue_req(prtt_pkg::OP_TICK, 8'd0, 32'd0, 32'd0);
      queue_req(prtt_pkg::OP_ADD, 8'd0, 32'd3, 32'd4);
      queue_req(prtt_pkg::OP_ADD, 8'd5, 32'd0, 32'd0);
      queue_req(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // fill the table; most tasks fall due on the first tick
      for (int i = 0; i < prtt_pkg::MAX_TASKS; i++) begin
         h = (i == prtt_pkg::MAX_TASKS - 1) ? 8'hFF : prtt_pkg::HANDLE_W'(i + 1);
         d = (i == 3) ? 32'hFFFF_FFFF : (i == 4) ? 32'hFFFF_FFFE : 32'd0;
         p = (i == 5) ? 32'hFFFF_FFFF : prtt_pkg::DATA_W'((i % 3) + 1);
         queue_req(prtt_pkg::OP_ADD, h, d, p);
      end
      queue_req(prtt_pkg::OP_ADD, 8'h42, 32'd1, 32'd7);
      queue_req(prtt_pkg::OP_ADD, 8'h43, 32'd1, 32'd0);
      queue_req(prtt_pkg::OP_TICK, 8'd0, 32'd0, 32'd0);
      queue_req(prtt_pkg::OP_TICK, 8'd0, 32'd0, 32'd0);
      queue_req(prtt_pkg::OP_CLEAR, 8'd0, 32'd0, 32'd0);

      // random part, mostly ticks mixed with adds with short delays and periods
      count = 0;
      while (count < RANDOM_REQS) begin
         r = $urandom_range(0, 99);
         op = (r < 3) ? OP_UNUSED : (r < 5) ? prtt_pkg::OP_CLEAR :
              (r < 38) ? prtt_pkg::OP_ADD : prtt_pkg::OP_TICK;
         h = ($urandom_range(0, 99) < 3) ? 8'd0 :
             prtt_pkg::HANDLE_W'($urandom_range(1, 255));
         r = $urandom_range(0, 99);
         d = (r < 80) ? prtt_pkg::DATA_W'($urandom_range(0, 4)) :
             (r < 88) ? prtt_pkg::DATA_W'($urandom()) :
             (r < 94) ? 32'hFFFF_FFFF : 32'hFFFF_FFFE;
         r = $urandom_range(0, 99);
         p = (r < 5) ? 32'd0 : (r < 85) ? prtt_pkg::DATA_W'($urandom_range(1, 8)) :
             (r < 95) ? prtt_pkg::DATA_W'($urandom()) : 32'hFFFF_FFFF;
         queue_req(op, h, d, p);
         if (op != OP_UNUSED) begin
            count++;
         end
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_WAIT) @(posedge clock);

      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
